// File: rtl/bqf_pkg.sv
package bqf_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 32;
   localparam int COEF_FRAC = 24;
   localparam int NUM_COEF  = 6;
   localparam int GAIN_IDX  = 5;
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W    = 4;

   localparam int ACC_W     = COEF_W + SAMPLE_W + 3;
   localparam int HI_W      = ACC_W - COEF_FRAC;
   localparam int LO_W      = COEF_FRAC;
   localparam int OPB_MAX0  = (SAMPLE_W > HI_W) ? SAMPLE_W : HI_W;
   localparam int OPB_MAX   = (OPB_MAX0 > LO_W) ? OPB_MAX0 : LO_W;
   localparam int MUL_A_W   = COEF_W + 1;
   localparam int MUL_B_W   = OPB_MAX + 1;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int RND_W     = LO_W + COEF_W + 1;
   localparam int HIPROD_W  = HI_W + COEF_W;
   localparam int SUM_W     = HIPROD_W + 1;
   localparam int Q_W       = SUM_W - COEF_FRAC;

   localparam logic [COEF_W-1:0] COEF_UNITY = COEF_W'(64'd1 << COEF_FRAC);
   localparam logic [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
      COEF_UNITY, '0, '0, '0, '0, COEF_UNITY
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FF_COEF_0,
      REG_FF_COEF_1,
      REG_FF_COEF_2,
      REG_FB_COEF_1,
      REG_FB_COEF_2,
      REG_NORM_GAIN
   } csr_reg_type;

   typedef enum logic [2:0] {
      A_FF0,
      A_FF1,
      A_FF2,
      A_FB1,
      A_FB2,
      A_GAIN_MAG
   } a_sel_type;

   typedef enum logic [2:0] {
      B_SAMPLE_IN,
      B_X1,
      B_X2,
      B_Y1,
      B_Y2,
      B_ACC_LO,
      B_ACC_HI
   } b_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_ABS
   } acc_op_type;

   typedef enum logic [1:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_OUT_BUSY
   } cond_type;

   typedef enum logic [STEP_W-1:0] {
      STEP_IDLE,
      STEP_MAC_1,
      STEP_MAC_2,
      STEP_MAC_3,
      STEP_MAC_4,
      STEP_MAC_5,
      STEP_ABS,
      STEP_RND_LO,
      STEP_RND_HI,
      STEP_FINISH
   } step_type;

   typedef struct packed {
      logic       take_req;
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      acc_op_type acc_op;
      logic       rnd_load;
      logic       finish;
      cond_type   cond;
      logic       restart;
      step_type   jump_tgt;
   } ucode_word_type;

   typedef struct packed {
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      acc_op_type acc_op;
      logic       rnd_load;
      logic       sample_load;
      logic       result_load;
   } dp_ctl_type;

   typedef struct packed {
      logic out_busy;
   } dp_stat_type;

endpackage

// File: rtl/bqf_sequencer.sv
module bqf_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bqf_pkg::dp_stat_type stat,
   output bqf_pkg::dp_ctl_type  ctl
);
   import bqf_pkg::*;

   step_type       step_ff;
   step_type       step_in;
   ucode_word_type word;
   logic           accept;
   logic           taken;

   // One control word per step; a taken condition loads the jump target.
   function automatic ucode_word_type ucode(input step_type step);
      ucode_word_type w;
      unique case (step)
         STEP_IDLE:
            w = '{1'b1, A_FF0, B_SAMPLE_IN, ACC_HOLD, 1'b0, 1'b0,
                  COND_NO_REQ, 1'b0, STEP_IDLE};
         STEP_MAC_1:
            w = '{1'b0, A_FF1, B_X1, ACC_LOAD, 1'b0, 1'b0,
                  COND_NEVER, 1'b0, STEP_IDLE};
         STEP_MAC_2:
            w = '{1'b0, A_FF2, B_X2, ACC_ADD, 1'b0, 1'b0,
                  COND_NEVER, 1'b0, STEP_IDLE};
         STEP_MAC_3:
            w = '{1'b0, A_FB1, B_Y1, ACC_ADD, 1'b0, 1'b0,
                  COND_NEVER, 1'b0, STEP_IDLE};
         STEP_MAC_4:
            w = '{1'b0, A_FB2, B_Y2, ACC_ADD, 1'b0, 1'b0,
                  COND_NEVER, 1'b0, STEP_IDLE};
         STEP_MAC_5:
            w = '{1'b0, A_FF0, B_SAMPLE_IN, ACC_ADD, 1'b0, 1'b0,
                  COND_NEVER, 1'b0, STEP_IDLE};
         STEP_ABS:
            w = '{1'b0, A_GAIN_MAG, B_ACC_LO, ACC_ABS, 1'b0, 1'b0,
                  COND_NEVER, 1'b0, STEP_IDLE};
         STEP_RND_LO:
            w = '{1'b0, A_GAIN_MAG, B_ACC_LO, ACC_HOLD, 1'b0, 1'b0,
                  COND_NEVER, 1'b0, STEP_IDLE};
         STEP_RND_HI:
            w = '{1'b0, A_GAIN_MAG, B_ACC_HI, ACC_HOLD, 1'b1, 1'b0,
                  COND_NEVER, 1'b0, STEP_IDLE};
         STEP_FINISH:
            w = '{1'b0, A_GAIN_MAG, B_ACC_HI, ACC_HOLD, 1'b0, 1'b1,
                  COND_OUT_BUSY, 1'b1, STEP_FINISH};
         default:
            w = '{1'b0, A_FF0, B_SAMPLE_IN, ACC_HOLD, 1'b0, 1'b0,
                  COND_NEVER, 1'b1, STEP_IDLE};
      endcase
      return w;
   endfunction

   always_comb begin
      word      = ucode(step_ff);
      accept    = req_valid & word.take_req;
      req_stall = ~word.take_req;
      ctl.a_sel       = word.a_sel;
      ctl.b_sel       = word.b_sel;
      ctl.acc_op      = word.acc_op;
      ctl.rnd_load    = word.rnd_load;
      ctl.sample_load = accept;
      ctl.result_load = word.finish & ~stat.out_busy;
   end

   always_comb begin
      case (word.cond)
         COND_NO_REQ:   taken = ~accept;
         COND_OUT_BUSY: taken = stat.out_busy;
         default:       taken = 1'b0;
      endcase
      if (taken) begin
         step_in = word.jump_tgt;
      end else if (word.restart) begin
         step_in = STEP_IDLE;
      end else begin
         step_in = step_type'(STEP_W'(step_ff) + STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// File: rtl/bqf_datapath.sv
module bqf_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bqf_pkg::dp_ctl_type                  ctl,
   output bqf_pkg::dp_stat_type                 stat,
   input  logic                                 csr_write,
   input  logic [bqf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bqf_pkg::COEF_W-1:0]           csr_data,
   input  logic signed [bqf_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic signed [bqf_pkg::SAMPLE_W-1:0]  rsp_sample_out
);
   import bqf_pkg::*;

   localparam logic [RND_W-1:0]    RND_HALF   = RND_W'(64'd1 << (2 * COEF_FRAC - 1));
   localparam logic [Q_W-1:0]      Q_MAXPOS   = Q_W'((64'd1 << (SAMPLE_W - 1)) - 64'd1);
   localparam logic [Q_W-1:0]      Q_MINMAG   = Q_MAXPOS + Q_W'(1);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

   logic [COEF_W-1:0]         coef_ff [NUM_COEF];
   logic [COEF_W-1:0]         coef_in [NUM_COEF];
   logic [COEF_W-1:0]         gain_mag;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic [ACC_W-1:0]          acc_ff;
   logic [ACC_W-1:0]          acc_in;
   logic                      neg_ff;
   logic                      neg_in;
   logic [RND_W-1:0]          rnd_ff;
   logic [SUM_W-1:0]          sum;
   logic [Q_W-1:0]            q;
   logic [SAMPLE_W-1:0]       res;
   logic [SAMPLE_W-1:0]       x0_ff;
   logic [SAMPLE_W-1:0]       x1_ff;
   logic [SAMPLE_W-1:0]       x2_ff;
   logic [SAMPLE_W-1:0]       y1_ff;
   logic [SAMPLE_W-1:0]       y2_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [SAMPLE_W-1:0]       rsp_data_ff;

   function automatic logic [MUL_A_W-1:0] coef_sx(input logic [COEF_W-1:0] c);
      return {c[COEF_W-1], c};
   endfunction

   function automatic logic [MUL_B_W-1:0] samp_sx(input logic [SAMPLE_W-1:0] s);
      return {{(MUL_B_W - SAMPLE_W){s[SAMPLE_W-1]}}, s};
   endfunction

   always_comb begin
      coef_in = coef_ff;
      if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            REG_FF_COEF_0: coef_in[0] = csr_data;
            REG_FF_COEF_1: coef_in[1] = csr_data;
            REG_FF_COEF_2: coef_in[2] = csr_data;
            REG_FB_COEF_1: coef_in[3] = csr_data;
            REG_FB_COEF_2: coef_in[4] = csr_data;
            REG_NORM_GAIN: coef_in[5] = csr_data;
            default:       coef_in = coef_ff;
         endcase
      end
   end

   assign gain_mag = coef_ff[GAIN_IDX][COEF_W-1] ? (~coef_ff[GAIN_IDX] + COEF_W'(1))
                                                 : coef_ff[GAIN_IDX];

   always_comb begin
      case (ctl.a_sel)
         A_FF0:      mul_a = coef_sx(coef_ff[0]);
         A_FF1:      mul_a = coef_sx(coef_ff[1]);
         A_FF2:      mul_a = coef_sx(coef_ff[2]);
         A_FB1:      mul_a = coef_sx(coef_ff[3]);
         A_FB2:      mul_a = coef_sx(coef_ff[4]);
         A_GAIN_MAG: mul_a = {1'b0, gain_mag};
         default:    mul_a = '0;
      endcase
      case (ctl.b_sel)
         B_SAMPLE_IN: mul_b = samp_sx(req_sample_in);
         B_X1:        mul_b = samp_sx(x1_ff);
         B_X2:        mul_b = samp_sx(x2_ff);
         B_Y1:        mul_b = samp_sx(y1_ff);
         B_Y2:        mul_b = samp_sx(y2_ff);
         B_ACC_LO:    mul_b = {{(MUL_B_W - LO_W){1'b0}}, acc_ff[LO_W-1:0]};
         B_ACC_HI:    mul_b = {{(MUL_B_W - HI_W){1'b0}}, acc_ff[ACC_W-1:LO_W]};
         default:     mul_b = '0;
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      acc_in = acc_ff;
      neg_in = neg_ff;
      case (ctl.acc_op)
         ACC_LOAD: acc_in = prod_ff[ACC_W-1:0];
         ACC_ADD:  acc_in = acc_ff + prod_ff[ACC_W-1:0];
         ACC_ABS: begin
            acc_in = acc_ff[ACC_W-1] ? (~acc_ff + ACC_W'(1)) : acc_ff;
            neg_in = acc_ff[ACC_W-1] ^ coef_ff[GAIN_IDX][COEF_W-1];
         end
         default:  acc_in = acc_ff;
      endcase
   end

   // The rounded magnitude is the high product plus the carried low half.
   always_comb begin
      sum = SUM_W'(prod_ff[HIPROD_W-1:0]) + SUM_W'(rnd_ff >> COEF_FRAC);
      q   = sum[SUM_W-1:COEF_FRAC];
      if (neg_ff) begin
         res = (q > Q_MINMAG) ? SAMPLE_MIN : (~q[SAMPLE_W-1:0] + SAMPLE_W'(1));
      end else begin
         res = (q > Q_MAXPOS) ? SAMPLE_MAX : q[SAMPLE_W-1:0];
      end
   end

   assign stat.out_busy = rsp_valid_ff & rsp_stall;

   always_comb begin
      if (ctl.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff      <= COEF_RESET;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef_ff      <= coef_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctl.result_load) begin
            x1_ff <= x0_ff;
            x2_ff <= x1_ff;
            y1_ff <= res;
            y2_ff <= y1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      if (ctl.sample_load) begin
         x0_ff <= req_sample_in;
      end
      if (ctl.rnd_load) begin
         rnd_ff <= prod_ff[RND_W-1:0] + RND_HALF;
      end
      if (ctl.result_load) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule

// File: rtl/peaking_biquad_filter.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_sample_in (signed 16)
// rsp       out        rsp_valid / rsp_stall  rsp_sample_out (signed 16)
// csr       in         csr_valid / csr_ready  csr_index (3), csr_data (32)
//
// After its transfer, a sample runs through the tap, absolute value, rounding and finish steps
// before the next sample can be taken, longer only while a result is held by rsp_stall.
// The work is done by one shared 33x28 multiplier, used for five taps and, after an
// absolute value, for the two halves of the gain product, which are then rounded.
// A new sample may be taken while the previous result still waits in the output register.
// Reset is synchronous and restores the default coefficients and clears the history.
module peaking_biquad_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [bqf_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bqf_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bqf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bqf_pkg::COEF_W-1:0]           csr_data
);
   import bqf_pkg::*;

   dp_ctl_type  ctl;
   dp_stat_type stat;
   logic        csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   bqf_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   bqf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .stat           (stat),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_sample_in  (req_sample_in),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

// File: rtl/bqf_checker.sv
module bqf_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [bqf_pkg::SAMPLE_W-1:0]  rsp_sample_out
);
   import bqf_pkg::*;

   logic req_xfer;

   assign req_xfer = req_valid & ~req_stall;

   // A sample transfer keeps the input closed for the nine working steps.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall ##1 req_stall ##1 req_stall ##1 req_stall ##1 req_stall
                   ##1 req_stall ##1 req_stall ##1 req_stall ##1 req_stall)
      else $error("input reopened before the sample was finished");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a sample in progress");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out))
      else $error("stalled result changed or vanished");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind peaking_biquad_filter bqf_checker u_bqf_checker (.*);
